FILE: rtl/mfmt_pkg.sv
package mfmt_pkg;

	// field widths
	localparam int ID_W      = 11;
	localparam int RATE_W    = 10;
	localparam int SLOT_W    = 4;
	localparam int KIND_W    = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 11;
	localparam int CNT_W     = 16;
	localparam int ENC_W     = 16;
	localparam int POS_W     = 30;
	localparam int BYTE_CNT  = 7;

	localparam int SLOT_COUNT = 10;

	// front to back queue
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = 1;
	localparam int Q_CNT_W = 2;

	// serial divider
	localparam int DIV_STEPS = 30;
	localparam int DIV_CNT_W = 5;

	// match kinds
	localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MOTOR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_KEY   = 2'd2;

	// slot numbers
	localparam logic [SLOT_W-1:0] SLOT_LIFT0   = 4'd0;
	localparam logic [SLOT_W-1:0] SLOT_LIFT1   = 4'd1;
	localparam logic [SLOT_W-1:0] SLOT_SLIDE0  = 4'd2;
	localparam logic [SLOT_W-1:0] SLOT_SLIDE1  = 4'd3;
	localparam logic [SLOT_W-1:0] SLOT_PITCH   = 4'd4;
	localparam logic [SLOT_W-1:0] SLOT_ROLL    = 4'd5;
	localparam logic [SLOT_W-1:0] SLOT_REACH0  = 4'd6;
	localparam logic [SLOT_W-1:0] SLOT_REACH1  = 4'd7;
	localparam logic [SLOT_W-1:0] SLOT_ASSIST0 = 4'd8;
	localparam logic [SLOT_W-1:0] SLOT_ASSIST1 = 4'd9;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LIFT_BASE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLIDE_BASE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_ID    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROLL_ID     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REACH_BASE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ASSIST_BASE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_ID      = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_POS_DIV     = 3'd7;

	// register reset values
	localparam logic [ID_W-1:0]   RST_LIFT_BASE   = 11'd513;
	localparam logic [ID_W-1:0]   RST_SLIDE_BASE  = 11'd515;
	localparam logic [ID_W-1:0]   RST_PITCH_ID    = 11'd517;
	localparam logic [ID_W-1:0]   RST_ROLL_ID     = 11'd518;
	localparam logic [ID_W-1:0]   RST_REACH_BASE  = 11'd513;
	localparam logic [ID_W-1:0]   RST_ASSIST_BASE = 11'd515;
	localparam logic [ID_W-1:0]   RST_KEY_ID      = 11'd768;
	localparam logic [RATE_W-1:0] RST_POS_DIV     = 10'd19;

	// encoder wrap thresholds
	localparam logic signed [ENC_W:0] WRAP_UP   = 17'sd4096;
	localparam logic signed [ENC_W:0] WRAP_DOWN = -17'sd4096;
	localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7fff;
	localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;
	// one turn spans 8191 counts: count*8191 = (count << 13) - count
	localparam int TURN_SHIFT = 13;

	// back end states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	typedef struct packed {
		logic [ID_W-1:0]   lift_base;
		logic [ID_W-1:0]   slide_base;
		logic [ID_W-1:0]   pitch_id;
		logic [ID_W-1:0]   roll_id;
		logic [ID_W-1:0]   reach_base;
		logic [ID_W-1:0]   assist_base;
		logic [ID_W-1:0]   key_id;
		logic [RATE_W-1:0] pos_div;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0]         kind;
		logic [SLOT_W-1:0]         slot;
		logic [BYTE_CNT-1:0][7:0]  data;
	} item_t;

	typedef struct packed {
		logic [Q_CNT_W-1:0] count;
	} front_stat_t;

	typedef struct packed {
		logic [1:0] state;
		logic       pop;
	} back_stat_t;

endpackage

FILE: rtl/mfmt_if.sv
interface mfmt_in_if;
	logic        valid;
	logic        ready;
	logic        bus;
	logic [10:0] frame_id;
	logic [7:0]  byte0;
	logic [7:0]  byte1;
	logic [7:0]  byte2;
	logic [7:0]  byte3;
	logic [7:0]  byte4;
	logic [7:0]  byte5;
	logic [7:0]  byte6;

	modport source (output valid, bus, frame_id, byte0, byte1, byte2, byte3, byte4, byte5,
		byte6, input ready);
	modport sink (input valid, bus, frame_id, byte0, byte1, byte2, byte3, byte4, byte5,
		byte6, output ready);
endinterface

interface mfmt_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         match_kind;
	logic [3:0]         motor_slot;
	logic [15:0]        encoder_word;
	logic [15:0]        speed_word;
	logic [15:0]        current_word;
	logic [7:0]         temperature;
	logic signed [15:0] turn_count;
	logic signed [29:0] total_position;
	logic signed [29:0] scaled_position;
	logic [7:0]         key_value;

	modport source (output valid, match_kind, motor_slot, encoder_word, speed_word,
		current_word, temperature, turn_count, total_position, scaled_position, key_value,
		input ready);
	modport sink (input valid, match_kind, motor_slot, encoder_word, speed_word,
		current_word, temperature, turn_count, total_position, scaled_position, key_value,
		output ready);
endinterface

FILE: rtl/mfmt_front.sv
module mfmt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  mfmt_pkg::cfg_t       cfg,
	mfmt_in_if.sink              frame,
	output mfmt_pkg::item_t      q_item,
	output logic                 q_valid,
	input  logic                 q_pop,
	output mfmt_pkg::front_stat_t stat
);
	import mfmt_pkg::*;

	// second id of a pair, formed one bit wider so base 2047 never wraps
	function automatic logic is_next(input logic [ID_W-1:0] id, input logic [ID_W-1:0] base);
		logic [ID_W:0] nxt;
		nxt = {1'b0, base} + {{ID_W{1'b0}}, 1'b1};
		return {1'b0, id} == nxt;
	endfunction

	item_t              route_c;
	item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               push;
	logic               pop;

	// classify the word: first match in slot order, then the key
	always_comb begin
		route_c.kind = KIND_NONE;
		route_c.slot = SLOT_LIFT0;
		route_c.data = {frame.byte6, frame.byte5, frame.byte4, frame.byte3, frame.byte2,
			frame.byte1, frame.byte0};
		if (!frame.bus) begin
			if (frame.frame_id == cfg.lift_base) begin
				route_c.kind = KIND_MOTOR;
				route_c.slot = SLOT_LIFT0;
			end else if (is_next(frame.frame_id, cfg.lift_base)) begin
				route_c.kind = KIND_MOTOR;
				route_c.slot = SLOT_LIFT1;
			end else if (frame.frame_id == cfg.slide_base) begin
				route_c.kind = KIND_MOTOR;
				route_c.slot = SLOT_SLIDE0;
			end else if (is_next(frame.frame_id, cfg.slide_base)) begin
				route_c.kind = KIND_MOTOR;
				route_c.slot = SLOT_SLIDE1;
			end else if (frame.frame_id == cfg.pitch_id) begin
				route_c.kind = KIND_MOTOR;
				route_c.slot = SLOT_PITCH;
			end else if (frame.frame_id == cfg.roll_id) begin
				route_c.kind = KIND_MOTOR;
				route_c.slot = SLOT_ROLL;
			end
		end else begin
			if (frame.frame_id == cfg.reach_base) begin
				route_c.kind = KIND_MOTOR;
				route_c.slot = SLOT_REACH0;
			end else if (is_next(frame.frame_id, cfg.reach_base)) begin
				route_c.kind = KIND_MOTOR;
				route_c.slot = SLOT_REACH1;
			end else if (frame.frame_id == cfg.assist_base) begin
				route_c.kind = KIND_MOTOR;
				route_c.slot = SLOT_ASSIST0;
			end else if (is_next(frame.frame_id, cfg.assist_base)) begin
				route_c.kind = KIND_MOTOR;
				route_c.slot = SLOT_ASSIST1;
			end else if (frame.frame_id == cfg.key_id) begin
				route_c.kind = KIND_KEY;
			end
		end
	end

	// queue handshake
	assign frame.ready = count_q != Q_CNT_W'(Q_DEPTH);
	assign push        = frame.valid && frame.ready;
	assign q_valid     = count_q != '0;
	assign pop         = q_pop && q_valid;
	assign q_item      = mem_q[rd_ptr_q];
	assign stat.count  = count_q;

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= route_c;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/mfmt_back.sv
module mfmt_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [mfmt_pkg::RATE_W-1:0] pos_div,
	input  mfmt_pkg::item_t             q_item,
	input  logic                        q_valid,
	output logic                        q_pop,
	mfmt_out_if.source                  result,
	output mfmt_pkg::back_stat_t        stat
);
	import mfmt_pkg::*;

	logic [1:0]              state_q;
	item_t                   item_q;
	logic [ENC_W-1:0]        enc_now_q  [SLOT_COUNT];
	logic [ENC_W-1:0]        enc_prev_q [SLOT_COUNT];
	logic signed [CNT_W-1:0] turn_q     [SLOT_COUNT];
	logic [7:0]              key_q;
	logic signed [CNT_W-1:0] cnt_q;
	logic [ENC_W-1:0]        enc_q;
	logic signed [POS_W-1:0] total_q;
	logic                    neg_q;
	logic [POS_W-1:0]        quo_q;
	logic [RATE_W-1:0]       rem_q;
	logic [RATE_W-1:0]       rate_q;
	logic [DIV_CNT_W-1:0]    step_q;

	logic signed [ENC_W:0]   diff_c;
	logic signed [CNT_W-1:0] cnt_c;
	logic [ENC_W-1:0]        enc_in_c;
	logic signed [POS_W-1:0] cnt_ext_c;
	logic signed [POS_W-1:0] total_c;
	logic [POS_W-1:0]        mag_c;
	logic [RATE_W+1:0]       trial_c;
	logic [RATE_W:0]         shifted_c;
	logic [POS_W-1:0]        scaled_c;
	logic                    load;

	assign q_pop      = (state_q == ST_IDLE) && q_valid;
	assign stat.state = state_q;
	assign stat.pop   = q_pop;

	// wrap detection on the two stored words, saturating count
	always_comb begin
		diff_c   = $signed({1'b0, enc_now_q[q_item.slot]}) -
			$signed({1'b0, enc_prev_q[q_item.slot]});
		cnt_c    = turn_q[q_item.slot];
		enc_in_c = {q_item.data[0], q_item.data[1]};
		if (diff_c > WRAP_UP) begin
			if (cnt_c != CNT_MIN) begin
				cnt_c = cnt_c - 16'sd1;
			end
		end else if (diff_c < WRAP_DOWN) begin
			if (cnt_c != CNT_MAX) begin
				cnt_c = cnt_c + 16'sd1;
			end
		end
	end

	// total = count*8191 + encoder, and its magnitude for the divider
	always_comb begin
		cnt_ext_c = POS_W'(cnt_q);
		total_c   = (cnt_ext_c <<< TURN_SHIFT) - cnt_ext_c + $signed({14'd0, enc_q});
		mag_c     = total_c[POS_W-1] ? POS_W'(-total_c) : POS_W'(total_c);
	end

	// one restoring step: bring in the next dividend bit, try the subtract
	assign shifted_c = {rem_q, quo_q[POS_W-1]};
	assign trial_c   = {1'b0, shifted_c} - {2'b00, rate_q};
	assign scaled_c  = neg_q ? POS_W'(-quo_q) : quo_q;
	assign load      = (state_q == ST_DONE) && (!result.valid || result.ready);

	// slot state and key latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				enc_now_q[i]  <= '0;
				enc_prev_q[i] <= '0;
				turn_q[i]     <= '0;
			end
			key_q <= '0;
		end else if (q_pop) begin
			if (q_item.kind == KIND_KEY) begin
				key_q <= q_item.data[0];
			end else if (q_item.kind == KIND_MOTOR) begin
				turn_q[q_item.slot]     <= cnt_c;
				enc_prev_q[q_item.slot] <= enc_now_q[q_item.slot];
				enc_now_q[q_item.slot]  <= enc_in_c;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						state_q <= (q_item.kind == KIND_MOTOR) ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
					step_q  <= '0;
				end
				ST_DIV: begin
					if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
					step_q <= step_q + 1'b1;
				end
				ST_DONE: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (q_pop) begin
					item_q <= q_item;
					cnt_q  <= cnt_c;
					enc_q  <= enc_in_c;
				end
			end
			ST_MUL: begin
				total_q <= total_c;
				neg_q   <= total_c[POS_W-1];
				quo_q   <= mag_c;
				rem_q   <= '0;
				rate_q  <= (pos_div == '0) ? RATE_W'(1) : pos_div;
			end
			ST_DIV: begin
				if (!trial_c[RATE_W+1]) begin
					rem_q <= trial_c[RATE_W-1:0];
				end else begin
					rem_q <= shifted_c[RATE_W-1:0];
				end
				quo_q <= {quo_q[POS_W-2:0], ~trial_c[RATE_W+1]};
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.valid <= 1'b0;
		end else if (load) begin
			result.valid <= 1'b1;
		end else if (result.ready) begin
			result.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result.match_kind <= item_q.kind;
			result.key_value  <= key_q;
			if (item_q.kind == KIND_MOTOR) begin
				result.motor_slot      <= item_q.slot;
				result.encoder_word    <= enc_q;
				result.speed_word      <= {item_q.data[2], item_q.data[3]};
				result.current_word    <= {item_q.data[4], item_q.data[5]};
				result.temperature     <= item_q.data[6];
				result.turn_count      <= cnt_q;
				result.total_position  <= total_q;
				result.scaled_position <= $signed(scaled_c);
			end else begin
				result.motor_slot      <= '0;
				result.encoder_word    <= '0;
				result.speed_word      <= '0;
				result.current_word    <= '0;
				result.temperature     <= '0;
				result.turn_count      <= '0;
				result.total_position  <= '0;
				result.scaled_position <= '0;
			end
		end
	end

endmodule

FILE: rtl/motor_feedback_multiturn_tracker.sv
// a motor word goes from the queue through the idle, multiply, divide and done states
// of the back end to result; a key or unmatched word goes from idle straight to done
// the back end takes a new word only in idle, done waits while result is stalled, and
// the 30-step serial divider paces motor words; a 2-word queue lets frame run ahead
// reset: arst_n clears the queue, slot encoders, turn counts and key latch at once,
// and loads the id and rate registers with their defaults
module motor_feedback_multiturn_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mfmt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mfmt_pkg::CFG_W-1:0]     cfg_wdata,
	mfmt_in_if.sink                        frame,
	mfmt_out_if.source                     result
);
	import mfmt_pkg::*;

	cfg_t        cfg_q;
	item_t       q_item;
	logic        q_valid;
	logic        q_pop;
	front_stat_t front_stat;
	back_stat_t  back_stat;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lift_base   <= RST_LIFT_BASE;
			cfg_q.slide_base  <= RST_SLIDE_BASE;
			cfg_q.pitch_id    <= RST_PITCH_ID;
			cfg_q.roll_id     <= RST_ROLL_ID;
			cfg_q.reach_base  <= RST_REACH_BASE;
			cfg_q.assist_base <= RST_ASSIST_BASE;
			cfg_q.key_id      <= RST_KEY_ID;
			cfg_q.pos_div     <= RST_POS_DIV;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LIFT_BASE:   cfg_q.lift_base   <= cfg_wdata;
				REG_SLIDE_BASE:  cfg_q.slide_base  <= cfg_wdata;
				REG_PITCH_ID:    cfg_q.pitch_id    <= cfg_wdata;
				REG_ROLL_ID:     cfg_q.roll_id     <= cfg_wdata;
				REG_REACH_BASE:  cfg_q.reach_base  <= cfg_wdata;
				REG_ASSIST_BASE: cfg_q.assist_base <= cfg_wdata;
				REG_KEY_ID:      cfg_q.key_id      <= cfg_wdata;
				REG_POS_DIV:     cfg_q.pos_div     <= cfg_wdata[RATE_W-1:0];
				default:         cfg_q             <= cfg_q;
			endcase
		end
	end

	mfmt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.frame   (frame),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.stat    (front_stat)
	);

	mfmt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pos_div  (cfg_q.pos_div),
		.q_item   (q_item),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.result   (result),
		.stat     (back_stat)
	);

	// queue never overfills
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_stat.count <= Q_CNT_W'(Q_DEPTH))
		else $error("queue count above depth");

	// back end never pops an empty queue
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.pop |-> front_stat.count != '0)
		else $error("pop from empty queue");

	// a new result only comes out of the finishing state
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(back_stat.state) == ST_DONE)
		else $error("result raised outside finishing state");

	// a motor word always goes through the adder stage right after its pop
	a_motor_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.pop && q_item.kind == KIND_MOTOR |=> back_stat.state == ST_MUL)
		else $error("motor word skipped the adder stage");

endmodule

FILE: sim/tb_motor_feedback_multiturn_tracker.sv
`timescale 1ns / 1ps

module tb_motor_feedback_multiturn_tracker;
	import mfmt_pkg::*;

	localparam int COUNTS_PER_TURN = 8191;
	localparam int NO_ROUTE        = -1;
	localparam int KEY_ROUTE       = 10;
	localparam int STALL_LIMIT     = 2000;
	localparam int RANDOM_FRAMES   = 140;
	localparam int PRINT_LIMIT     = 20;

	typedef struct packed {
		logic                     bus;
		logic [ID_W-1:0]          id;
		logic [BYTE_CNT-1:0][7:0] data;
	} frame_t;

	typedef struct packed {
		logic [KIND_W-1:0]       kind;
		logic [SLOT_W-1:0]       slot;
		logic [15:0]             enc;
		logic [15:0]             speed;
		logic [15:0]             current;
		logic [7:0]              temp;
		logic signed [CNT_W-1:0] turns;
		logic signed [POS_W-1:0] total;
		logic signed [POS_W-1:0] scaled;
		logic [7:0]              key;
	} feedback_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]   cfg_wdata;

	mfmt_in_if  frame_if ();
	mfmt_out_if result_if ();

	motor_feedback_multiturn_tracker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.frame     (frame_if),
		.result    (result_if)
	);

	always #5 clk = ~clk;

	// tracker copy: registers, slot encoders, turn counts, key latch
	logic [CFG_W-1:0] cfg_model [8];
	logic [15:0]      enc_now_model  [SLOT_COUNT] = '{default: '0};
	logic [15:0]      enc_prev_model [SLOT_COUNT] = '{default: '0};
	int               turn_model     [SLOT_COUNT] = '{default: 0};
	logic [7:0]       key_model = '0;

	// encoder values the stimulus last chose per slot
	logic [15:0] gen_enc [SLOT_COUNT] = '{default: '0};

	frame_t    frames_to_send [$];
	feedback_t feedback_due [$];
	frame_t    frame_on_bus;

	int send_idle;
	int recv_idle;
	int error_count;
	int results_seen;
	int motor_seen;
	int key_seen;
	int none_seen;
	int steps_down;
	int steps_up;
	int steps_held;
	int stall_cycles;

	// route by bus and id, first match in slot order, then the key
	function automatic int route_frame(input logic bus, input logic [ID_W-1:0] id);
		logic [ID_W:0] id12;
		id12 = {1'b0, id};
		if (!bus) begin
			if (id12 == {1'b0, cfg_model[REG_LIFT_BASE]}) return 0;
			if (id12 == {1'b0, cfg_model[REG_LIFT_BASE]} + 12'd1) return 1;
			if (id12 == {1'b0, cfg_model[REG_SLIDE_BASE]}) return 2;
			if (id12 == {1'b0, cfg_model[REG_SLIDE_BASE]} + 12'd1) return 3;
			if (id12 == {1'b0, cfg_model[REG_PITCH_ID]}) return 4;
			if (id12 == {1'b0, cfg_model[REG_ROLL_ID]}) return 5;
		end else begin
			if (id12 == {1'b0, cfg_model[REG_REACH_BASE]}) return 6;
			if (id12 == {1'b0, cfg_model[REG_REACH_BASE]} + 12'd1) return 7;
			if (id12 == {1'b0, cfg_model[REG_ASSIST_BASE]}) return 8;
			if (id12 == {1'b0, cfg_model[REG_ASSIST_BASE]} + 12'd1) return 9;
			if (id12 == {1'b0, cfg_model[REG_KEY_ID]}) return KEY_ROUTE;
		end
		return NO_ROUTE;
	endfunction

	// expected result of one accepted frame, advancing the tracker copy
	function automatic feedback_t predict_feedback(input frame_t f);
		feedback_t r;
		int        slot;
		int        diff;
		int        cnt;
		int        total;
		int        rate;
		int        scaled;
		logic [15:0] enc;
		r = '0;
		slot = route_frame(f.bus, f.id);
		if (slot == KEY_ROUTE) begin
			key_model = f.data[0];
			r.kind = KIND_KEY;
		end else if (slot != NO_ROUTE) begin
			enc = {f.data[0], f.data[1]};
			// wrap test uses the two earlier words, so the count lags one frame
			diff = int'(enc_now_model[slot]) - int'(enc_prev_model[slot]);
			cnt = turn_model[slot];
			if (diff > WRAP_UP) begin
				if (cnt > CNT_MIN) begin
					cnt--;
					steps_down++;
				end else begin
					steps_held++;
				end
			end else if (diff < WRAP_DOWN) begin
				if (cnt < CNT_MAX) begin
					cnt++;
					steps_up++;
				end else begin
					steps_held++;
				end
			end
			turn_model[slot] = cnt;
			enc_prev_model[slot] = enc_now_model[slot];
			enc_now_model[slot] = enc;
			total = cnt * COUNTS_PER_TURN + int'(enc);
			rate = int'(cfg_model[REG_POS_DIV]);
			if (rate == 0) rate = 1;
			scaled = total / rate;
			r.kind = KIND_MOTOR;
			r.slot = SLOT_W'(slot);
			r.enc = enc;
			r.speed = {f.data[2], f.data[3]};
			r.current = {f.data[4], f.data[5]};
			r.temp = f.data[6];
			r.turns = CNT_W'(cnt);
			r.total = POS_W'(total);
			r.scaled = POS_W'(scaled);
		end
		r.key = key_model;
		return r;
	endfunction

	task automatic report_error(input string msg);
		error_count++;
		if (error_count <= PRINT_LIMIT) $display("[%0t] error %0d: %s", $realtime, error_count, msg);
	endtask

	task automatic check_field(input string name, input logic signed [31:0] got,
			input logic signed [31:0] want);
		if (got !== want)
			report_error($sformatf("result %0d %s: got %0d, expected %0d", results_seen, name,
				got, want));
	endtask

	// register write, only while the block is idle
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		cfg_model[idx] = (idx == REG_POS_DIV) ? (value & 11'h3ff) : value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_config();
		write_reg(REG_LIFT_BASE, CFG_W'($urandom_range(0, 2047)));
		write_reg(REG_SLIDE_BASE, CFG_W'($urandom_range(0, 2047)));
		write_reg(REG_PITCH_ID, CFG_W'($urandom_range(0, 2047)));
		write_reg(REG_ROLL_ID, CFG_W'($urandom_range(0, 2047)));
		write_reg(REG_REACH_BASE, CFG_W'($urandom_range(0, 2047)));
		write_reg(REG_ASSIST_BASE, CFG_W'($urandom_range(0, 2047)));
		write_reg(REG_KEY_ID, CFG_W'($urandom_range(0, 2047)));
		write_reg(REG_POS_DIV, CFG_W'($urandom_range(0, 2047)));
	endtask

	// wait until every frame is sent and every result has come back
	task automatic wait_quiet();
		do @(negedge clk);
		while (frames_to_send.size() != 0 || frame_if.valid || feedback_due.size() != 0);
		repeat (40) @(posedge clk);
	endtask

	function automatic frame_t make_frame(input logic bus, input logic [ID_W-1:0] id,
			input logic [15:0] enc, input logic [7:0] fill);
		frame_t f;
		f.bus = bus;
		f.id = id;
		f.data[0] = enc[15:8];
		f.data[1] = enc[7:0];
		for (int i = 2; i < BYTE_CNT; i++) f.data[i] = fill;
		return f;
	endfunction

	// frame addressed to a slot under the current ids, random pass-through bytes
	function automatic frame_t motor_frame(input int slot, input logic [15:0] enc);
		frame_t       f;
		logic [ID_W:0] id;
		case (slot)
			0: id = {1'b0, cfg_model[REG_LIFT_BASE]};
			1: id = {1'b0, cfg_model[REG_LIFT_BASE]} + 12'd1;
			2: id = {1'b0, cfg_model[REG_SLIDE_BASE]};
			3: id = {1'b0, cfg_model[REG_SLIDE_BASE]} + 12'd1;
			4: id = {1'b0, cfg_model[REG_PITCH_ID]};
			5: id = {1'b0, cfg_model[REG_ROLL_ID]};
			6: id = {1'b0, cfg_model[REG_REACH_BASE]};
			7: id = {1'b0, cfg_model[REG_REACH_BASE]} + 12'd1;
			8: id = {1'b0, cfg_model[REG_ASSIST_BASE]};
			default: id = {1'b0, cfg_model[REG_ASSIST_BASE]} + 12'd1;
		endcase
		f.bus = (slot >= 6);
		f.id = id[ID_W-1:0];
		f.data[0] = enc[15:8];
		f.data[1] = enc[7:0];
		for (int i = 2; i < BYTE_CNT; i++) f.data[i] = 8'($urandom);
		return f;
	endfunction

	// encoder walk: random jumps, small moves and moves across the wrap threshold
	function automatic logic [15:0] next_encoder(input int slot);
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 3) gen_enc[slot] = 16'($urandom);
		else if (pick < 6) gen_enc[slot] = gen_enc[slot] + 16'($urandom_range(0, 4096)) - 16'd2048;
		else if (pick < 8) gen_enc[slot] = gen_enc[slot] + 16'd4097 + 16'($urandom_range(0, 20000));
		else gen_enc[slot] = gen_enc[slot] - 16'd4097 - 16'($urandom_range(0, 20000));
		return gen_enc[slot];
	endfunction

	task automatic queue_random(input int count);
		int     pick;
		int     slot;
		frame_t f;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				slot = $urandom_range(0, SLOT_COUNT - 1);
				f = motor_frame(slot, next_encoder(slot));
			end else if (pick < 85) begin
				f = make_frame(1'b1, cfg_model[REG_KEY_ID], 16'($urandom), 8'($urandom));
			end else begin
				f = make_frame(1'($urandom), ID_W'($urandom), 16'($urandom), 8'($urandom));
				for (int j = 2; j < BYTE_CNT; j++) f.data[j] = 8'($urandom);
			end
			frames_to_send.push_back(f);
		end
	endtask

	// frame driver: holds a word until accepted, random gaps between words
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_if.valid <= 1'b0;
			frame_if.bus <= 1'b0;
			frame_if.frame_id <= '0;
			frame_if.byte0 <= '0;
			frame_if.byte1 <= '0;
			frame_if.byte2 <= '0;
			frame_if.byte3 <= '0;
			frame_if.byte4 <= '0;
			frame_if.byte5 <= '0;
			frame_if.byte6 <= '0;
		end else begin
			if (frame_if.valid && frame_if.ready) begin
				feedback_due.push_back(predict_feedback(frame_on_bus));
			end
			if (!frame_if.valid || frame_if.ready) begin
				if (frames_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					frame_on_bus = frames_to_send.pop_front();
					frame_if.valid <= 1'b1;
					frame_if.bus <= frame_on_bus.bus;
					frame_if.frame_id <= frame_on_bus.id;
					frame_if.byte0 <= frame_on_bus.data[0];
					frame_if.byte1 <= frame_on_bus.data[1];
					frame_if.byte2 <= frame_on_bus.data[2];
					frame_if.byte3 <= frame_on_bus.data[3];
					frame_if.byte4 <= frame_on_bus.data[4];
					frame_if.byte5 <= frame_on_bus.data[5];
					frame_if.byte6 <= frame_on_bus.data[6];
				end else begin
					frame_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compare each accepted word with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		feedback_t want;
		if (!arst_n) begin
			result_if.ready <= 1'b0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				if (feedback_due.size() == 0) begin
					report_error($sformatf("result %0d arrived with no frame outstanding",
						results_seen));
				end else begin
					want = feedback_due.pop_front();
					check_field("match_kind", 32'(result_if.match_kind), 32'(want.kind));
					check_field("motor_slot", 32'(result_if.motor_slot), 32'(want.slot));
					check_field("encoder_word", 32'(result_if.encoder_word), 32'(want.enc));
					check_field("speed_word", 32'(result_if.speed_word), 32'(want.speed));
					check_field("current_word", 32'(result_if.current_word),
						32'(want.current));
					check_field("temperature", 32'(result_if.temperature), 32'(want.temp));
					check_field("turn_count", 32'(result_if.turn_count), 32'(want.turns));
					check_field("total_position", 32'(result_if.total_position),
						32'(want.total));
					check_field("scaled_position", 32'(result_if.scaled_position),
						32'(want.scaled));
					check_field("key_value", 32'(result_if.key_value), 32'(want.key));
					case (want.kind)
						KIND_MOTOR: motor_seen++;
						KIND_KEY:   key_seen++;
						default:    none_seen++;
					endcase
				end
				results_seen++;
			end
			result_if.ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// watchdog: work outstanding but no word moving on either side
	always @(posedge clk) begin
		if ((frame_if.valid && frame_if.ready) || (result_if.valid && result_if.ready)) begin
			stall_cycles = 0;
		end else if (frames_to_send.size() != 0 || frame_if.valid || feedback_due.size() != 0) begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("[%0t] no word moved for %0d cycles", $realtime, STALL_LIMIT);
				$display("motor_feedback_multiturn_tracker test failed");
				$finish;
			end
		end
	end

	initial begin
		frame_t pair_frame;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		error_count = 0;
		results_seen = 0;
		motor_seen = 0;
		key_seen = 0;
		none_seen = 0;
		steps_down = 0;
		steps_up = 0;
		steps_held = 0;
		stall_cycles = 0;
		send_idle = 34;
		recv_idle = 82;

		cfg_model[REG_LIFT_BASE] = RST_LIFT_BASE;
		cfg_model[REG_SLIDE_BASE] = RST_SLIDE_BASE;
		cfg_model[REG_PITCH_ID] = RST_PITCH_ID;
		cfg_model[REG_ROLL_ID] = RST_ROLL_ID;
		cfg_model[REG_REACH_BASE] = RST_REACH_BASE;
		cfg_model[REG_ASSIST_BASE] = RST_ASSIST_BASE;
		cfg_model[REG_KEY_ID] = RST_KEY_ID;
		cfg_model[REG_POS_DIV] = {1'b0, RST_POS_DIV};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset ids: lift0 steps down then back up across the threshold
		frames_to_send.push_back(motor_frame(0, 16'h0000));
		frames_to_send.push_back(make_frame(1'b0, cfg_model[REG_LIFT_BASE], 16'd4097, 8'hff));
		frames_to_send.push_back(make_frame(1'b0, cfg_model[REG_LIFT_BASE], 16'h0000, 8'h00));
		frames_to_send.push_back(make_frame(1'b0, cfg_model[REG_LIFT_BASE], 16'hffff, 8'hff));
		// a difference of exactly the threshold leaves the count alone
		frames_to_send.push_back(motor_frame(1, 16'h0000));
		frames_to_send.push_back(motor_frame(1, 16'd4096));
		frames_to_send.push_back(motor_frame(1, 16'h0000));
		frames_to_send.push_back(motor_frame(1, 16'd4096));
		// the remaining slots with byte extremes
		for (int s = 2; s < SLOT_COUNT; s++) begin
			pair_frame = motor_frame(s, 16'h0);
			frames_to_send.push_back(make_frame(s >= 6, pair_frame.id,
				(s % 2) ? 16'hffff : 16'h0000, (s % 2) ? 8'h00 : 8'hff));
		end
		frames_to_send.push_back(make_frame(1'b1, cfg_model[REG_KEY_ID], 16'hff00, 8'h00));
		frames_to_send.push_back(make_frame(1'b1, cfg_model[REG_KEY_ID], 16'ha5ff, 8'hff));
		// key id on the wrong bus, pitch id on the wrong bus
		frames_to_send.push_back(make_frame(1'b0, cfg_model[REG_KEY_ID], 16'h1234, 8'h55));
		frames_to_send.push_back(make_frame(1'b1, cfg_model[REG_PITCH_ID], 16'h4321, 8'haa));
		wait_quiet();

		// overlapping ids: first slot wins, motor wins over key; rate masked to zero
		write_reg(REG_PITCH_ID, 11'd513);
		write_reg(REG_ROLL_ID, 11'd516);
		write_reg(REG_REACH_BASE, 11'd600);
		write_reg(REG_ASSIST_BASE, 11'd700);
		write_reg(REG_KEY_ID, 11'd600);
		write_reg(REG_POS_DIV, 11'h400);
		frames_to_send.push_back(make_frame(1'b0, 11'd513, 16'h8000, 8'h3c));
		frames_to_send.push_back(make_frame(1'b0, 11'd516, 16'h7fff, 8'hc3));
		frames_to_send.push_back(make_frame(1'b1, 11'd600, 16'h0f0f, 8'h81));
		wait_quiet();

		// id extremes: base at the top has no second id, largest rate
		write_reg(REG_LIFT_BASE, 11'd2047);
		write_reg(REG_SLIDE_BASE, 11'd100);
		write_reg(REG_PITCH_ID, 11'd2046);
		write_reg(REG_ROLL_ID, 11'd1);
		write_reg(REG_REACH_BASE, 11'd2047);
		write_reg(REG_ASSIST_BASE, 11'd0);
		write_reg(REG_KEY_ID, 11'd5);
		write_reg(REG_POS_DIV, 11'h7ff);
		frames_to_send.push_back(make_frame(1'b0, 11'd0, 16'hffff, 8'hff));
		frames_to_send.push_back(make_frame(1'b1, 11'd0, 16'hffff, 8'h00));
		frames_to_send.push_back(make_frame(1'b0, 11'd2047, 16'hffff, 8'hff));
		frames_to_send.push_back(make_frame(1'b1, 11'd5, 16'h5a00, 8'h00));
		wait_quiet();

		// random traffic, slow receiver
		random_config();
		queue_random(RANDOM_FRAMES);
		wait_quiet();

		// random traffic, slow sender
		send_idle = 82;
		recv_idle = 34;
		random_config();
		queue_random(RANDOM_FRAMES);
		wait_quiet();

		// random traffic, full rate
		send_idle = 0;
		recv_idle = 0;
		random_config();
		queue_random(RANDOM_FRAMES);
		wait_quiet();

		$display("checked %0d results: %0d motor, %0d key, %0d unmatched",
			results_seen, motor_seen, key_seen, none_seen);
		$display("turn count: %0d steps down, %0d up, %0d held at a limit; %0d errors",
			steps_down, steps_up, steps_held, error_count);
		if (error_count == 0) begin
			$display("motor_feedback_multiturn_tracker test passed");
		end else begin
			$display("motor_feedback_multiturn_tracker test failed");
		end
		$finish;
	end

endmodule

FILE: sim.f
rtl/mfmt_pkg.sv
rtl/mfmt_if.sv
rtl/mfmt_front.sv
rtl/mfmt_back.sv
rtl/motor_feedback_multiturn_tracker.sv
sim/tb_motor_feedback_multiturn_tracker.sv
